// ===== design/asr_pkg.sv =====
// Shared types, constants and helper functions for the shade ramp block.
// No dependencies.
package asr_pkg;

   typedef struct packed {
      logic [7:0] accent_red;
      logic [7:0] accent_green;
      logic [7:0] accent_blue;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] shade_index;
      logic [7:0] shade_red;
      logic [7:0] shade_green;
      logic [7:0] shade_blue;
      logic       last_shade;
   } rsp_beat_type;

   // accent in HSV form, held while its seven shades are produced
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [18:0] hue;
      logic [15:0] sat;
      logic [15:0] val;
   } hsv_type;

   localparam int unsigned NUM_SHADES  = 7;
   localparam int unsigned ACCENT_SHADE = 3;
   localparam int unsigned DIV_WIDTH   = 24;

   localparam logic [16:0] SIXTH = 17'd65536;

   function automatic logic [16:0] dark_val(input logic [1:0] k);
      case (k)
         2'd0:    dark_val = 17'd24143;
         2'd1:    dark_val = 17'd34059;
         default: dark_val = 17'd47428;
      endcase
   endfunction

   function automatic logic [16:0] light_frac(input logic [1:0] k);
      case (k)
         2'd0:    light_frac = 17'd47042;
         2'd1:    light_frac = 17'd58537;
         default: light_frac = 17'd65536;
      endcase
   endfunction

   function automatic logic [16:0] light_sat(input logic [1:0] k);
      case (k)
         2'd0:    light_sat = 17'd47487;
         2'd1:    light_sat = 17'd30691;
         default: light_sat = 17'd21496;
      endcase
   endfunction

   // (a*b + 32768) >> 16, a 16-bit fraction, b Q0.16 up to 1.0
   function automatic logic [16:0] mulq16(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] p;
      p = a * b + 34'd32768;
      mulq16 = p[32:16];
   endfunction

   // (c*255 + 32767) / 65535 clamped, c < 2^17. Quotient q = n/65535 for
   // n < 2^26: q0 = (n + (n>>16) + 1) >> 16 corrected by one compare.
   function automatic logic [7:0] to8(input logic [16:0] c);
      logic [25:0] n;
      logic [26:0] t;
      logic [10:0] q;
      logic [26:0] back;
      n = c * 26'd255 + 26'd32767;
      t = {1'b0, n} + {11'd0, n[25:16]} + 27'd1;
      q = t[26:16];
      back = q * 27'd65535;
      if (back > {1'b0, n}) q = q - 11'd1;
      to8 = (q > 11'd255) ? 8'd255 : q[7:0];
   endfunction

endpackage

// ===== design/accent_shade_ramp_top.sv =====
// Shade ramp top: one accent in, seven shades out, one shade per cycle
// while the output is not stalled. Path from accept to the first shade:
// max/min stage, divider pipeline, hue assembly, shade hold, 4 back-end stages.
// The sequencer issues the shades of its held accent; the front end stalls
// while its result waits. The front end and back end are fully pipelined.
// Reset: synchronous, active high; clears all valid bits and the sequencer.
// Depends on asr_pkg, asr_rgb2hsv, asr_hsv2rgb.
module accent_shade_ramp_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  asr_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output asr_pkg::rsp_beat_type rsp_data
);
   logic advance;
   assign advance = !(rsp_valid && rsp_stall);

   // the front end only moves when the sequencer can take what it delivers
   logic fe_vld, fe_adv;
   asr_pkg::hsv_type fe_hsv;

   logic hold_vld_ff, hold_vld_in;
   asr_pkg::hsv_type hold_ff;
   logic [2:0] idx_ff, idx_in;
   logic take;

   // sequencer free when empty or issuing its last shade this cycle
   assign take   = !hold_vld_ff || (advance && idx_ff == 3'(asr_pkg::NUM_SHADES - 1));
   assign fe_adv = advance && (take || !fe_vld);
   assign req_stall = !fe_adv;

   asr_rgb2hsv u_front (
      .clock, .reset, .advance(fe_adv), .in_valid(req_valid), .in_beat(req_data),
      .out_valid(fe_vld), .out_hsv(fe_hsv));

   always_comb begin
      hold_vld_in = hold_vld_ff;
      idx_in = idx_ff;
      if (hold_vld_ff && advance) begin
         if (idx_ff == 3'(asr_pkg::NUM_SHADES - 1)) begin
            hold_vld_in = 1'b0; idx_in = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
      if (take && fe_vld && fe_adv) begin
         hold_vld_in = 1'b1; idx_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0; idx_ff <= 3'd0;
      end else begin
         hold_vld_ff <= hold_vld_in; idx_ff <= idx_in;
      end
      if (take && fe_vld && fe_adv) hold_ff <= fe_hsv;
   end

   asr_hsv2rgb u_back (
      .clock, .reset, .advance, .in_valid(hold_vld_ff && advance), .in_index(idx_ff),
      .in_hsv(hold_ff), .out_valid(rsp_valid), .out_beat(rsp_data));
endmodule

// ===== design/asr_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
// Depends on asr_pkg.
module asr_divider #(
   parameter int unsigned NUM_WIDTH = asr_pkg::DIV_WIDTH,
   parameter int unsigned DEN_WIDTH = 8,
   parameter int unsigned TAG_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NUM_WIDTH-1:0] in_num,
   input  logic [DEN_WIDTH-1:0] in_den,
   input  logic [TAG_WIDTH-1:0] in_tag,
   output logic                 out_valid,
   output logic [NUM_WIDTH-1:0] out_quo,
   output logic [TAG_WIDTH-1:0] out_tag
);
   localparam int unsigned RW = DEN_WIDTH + 1;

   logic                 vld_ff [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH+1];
   logic [RW-1:0]        rem_ff [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH+1];
   logic [TAG_WIDTH-1:0] tag_ff [NUM_WIDTH+1];

   always_comb begin
      vld_ff[0] = in_valid;
      num_ff[0] = in_num;
      rem_ff[0] = '0;
      den_ff[0] = in_den;
      tag_ff[0] = in_tag;
   end

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
      logic [RW:0]          trial_in;
      logic [RW-1:0]        rem_in;
      logic [NUM_WIDTH-1:0] num_in;
      logic                 v_q;
      logic [NUM_WIDTH-1:0] n_q;
      logic [RW-1:0]        r_q;
      logic [DEN_WIDTH-1:0] d_q;
      logic [TAG_WIDTH-1:0] t_q;
      always_comb begin
         trial_in = {rem_ff[i], num_ff[i][NUM_WIDTH-1]};
         num_in = {num_ff[i][NUM_WIDTH-2:0], 1'b0};
         if (trial_in >= {2'b0, den_ff[i]}) begin
            rem_in = RW'(trial_in - {2'b0, den_ff[i]});
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial_in[RW-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) v_q <= 1'b0;
         else if (advance) v_q <= vld_ff[i];
         if (advance) begin
            n_q <= num_in;
            r_q <= rem_in;
            d_q <= den_ff[i];
            t_q <= tag_ff[i];
         end
      end
      always_comb begin
         vld_ff[i+1] = v_q;
         num_ff[i+1] = n_q;
         rem_ff[i+1] = r_q;
         den_ff[i+1] = d_q;
         tag_ff[i+1] = t_q;
      end
   end

   assign out_valid = vld_ff[NUM_WIDTH];
   assign out_quo   = num_ff[NUM_WIDTH];
   assign out_tag   = tag_ff[NUM_WIDTH];
endmodule

// ===== design/asr_rgb2hsv.sv =====
// Front end: RGB to HSV conversion pipeline, separate hue and sat dividers.
// Depends on asr_pkg and asr_divider.
module asr_rgb2hsv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  asr_pkg::req_beat_type in_beat,
   output logic                 out_valid,
   output asr_pkg::hsv_type     out_hsv
);
   localparam int unsigned DW = asr_pkg::DIV_WIDTH;

   // stage 1: max, min, signed difference, sector
   logic        s1_vld_ff;
   asr_pkg::req_beat_type s1_rgb_ff, s1_rgb_in;
   logic [7:0]  s1_mx_ff, s1_mx_in, s1_dl_ff, s1_dl_in;
   logic [7:0]  s1_mag_ff, s1_mag_in;
   logic        s1_neg_ff, s1_neg_in;
   logic [1:0]  s1_sec_ff, s1_sec_in;

   always_comb begin
      logic [7:0] r, g, b, mn;
      logic signed [8:0] d;
      r = in_beat.accent_red; g = in_beat.accent_green; b = in_beat.accent_blue;
      s1_rgb_in = in_beat;
      s1_mx_in = r; mn = r;
      if (g > s1_mx_in) s1_mx_in = g;
      if (b > s1_mx_in) s1_mx_in = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s1_dl_in = s1_mx_in - mn;
      if (s1_mx_in == r) begin
         d = $signed({1'b0, g}) - $signed({1'b0, b}); s1_sec_in = 2'd0;
      end else if (s1_mx_in == g) begin
         d = $signed({1'b0, b}) - $signed({1'b0, r}); s1_sec_in = 2'd1;
      end else begin
         d = $signed({1'b0, r}) - $signed({1'b0, g}); s1_sec_in = 2'd2;
      end
      s1_neg_in = d[8];
      s1_mag_in = d[8] ? 8'(-d) : d[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (advance) s1_vld_ff <= in_valid;
      if (advance) begin
         s1_rgb_ff <= s1_rgb_in; s1_mx_ff <= s1_mx_in; s1_dl_ff <= s1_dl_in;
         s1_mag_ff <= s1_mag_in; s1_neg_ff <= s1_neg_in; s1_sec_ff <= s1_sec_in;
      end
   end

   // hue: (mag*65536 + delta/2) / delta ; saturation: (delta*65535 + mx/2) / mx
   // tag: rgb, max, delta nonzero, hue sign, sector, max nonzero
   localparam int unsigned TW = 24 + 8 + 1 + 1 + 2 + 1;
   logic [DW-1:0] hnum, snum, hquo, squo;
   logic [7:0]    hden, sden;
   logic [TW-1:0] tag_in, tag_out, stag_unused;
   logic          hv, sv;

   always_comb begin
      hnum = DW'({s1_mag_ff, 16'd0}) + DW'(s1_dl_ff[7:1]);
      hden = (s1_dl_ff == 8'd0) ? 8'd1 : s1_dl_ff;
      snum = DW'(s1_dl_ff * 24'd65535) + DW'(s1_mx_ff[7:1]);
      sden = (s1_mx_ff == 8'd0) ? 8'd1 : s1_mx_ff;
      tag_in = {s1_rgb_ff, s1_mx_ff, s1_dl_ff != 8'd0,
                s1_neg_ff, s1_sec_ff, s1_mx_ff != 8'd0};
   end

   asr_divider #(.NUM_WIDTH(DW), .DEN_WIDTH(8), .TAG_WIDTH(TW)) u_hue_div (
      .clock, .reset, .advance, .in_valid(s1_vld_ff), .in_num(hnum), .in_den(hden),
      .in_tag(tag_in), .out_valid(hv), .out_quo(hquo), .out_tag(tag_out));

   asr_divider #(.NUM_WIDTH(DW), .DEN_WIDTH(8), .TAG_WIDTH(TW)) u_sat_div (
      .clock, .reset, .advance, .in_valid(s1_vld_ff), .in_num(snum), .in_den(sden),
      .in_tag(tag_in), .out_valid(sv), .out_quo(squo), .out_tag(stag_unused));

   // final stage: assemble hue with sector offset and wrap, saturation and value
   logic             o_vld_ff;
   asr_pkg::hsv_type o_hsv_ff, o_hsv_in;

   always_comb begin
      logic [7:0]  mx;
      logic        nz, neg, mxnz;
      logic [1:0]  sec;
      logic signed [20:0] hs;
      logic [20:0] q;
      o_hsv_in = '0;
      {o_hsv_in.red, o_hsv_in.green, o_hsv_in.blue} = tag_out[TW-1:TW-24];
      mx   = tag_out[TW-25:TW-32];
      nz   = tag_out[4];
      neg  = tag_out[3];
      sec  = tag_out[2:1];
      mxnz = tag_out[0];
      q = 21'(hquo);
      hs = neg ? -$signed(q) : $signed(q);
      hs = hs + $signed({2'b0, sec, 17'd0});
      if (hs < 0) hs = hs + 21'sd393216;
      if (hs >= 21'sd393216) hs = hs - 21'sd393216;
      o_hsv_in.hue = nz ? hs[18:0] : 19'd0;
      o_hsv_in.sat = mxnz ? squo[15:0] : 16'd0;
      o_hsv_in.val = {mx, mx};
   end

   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else if (advance) o_vld_ff <= hv & sv;
      if (advance) o_hsv_ff <= o_hsv_in;
   end

   assign out_valid = o_vld_ff;
   assign out_hsv   = o_hsv_ff;
endmodule

// ===== design/asr_hsv2rgb.sv =====
// Back end: per-shade factor, chroma, sector mix and 8-bit rounding, four stages.
// Depends on asr_pkg.
module asr_hsv2rgb (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [2:0]           in_index,
   input  asr_pkg::hsv_type     in_hsv,
   output logic                 out_valid,
   output asr_pkg::rsp_beat_type out_beat
);
   // stage A: shade value and saturation
   logic a_vld_ff;
   logic [2:0] a_idx_ff;
   asr_pkg::hsv_type a_hsv_ff;
   logic [16:0] a_v_ff, a_v_in, a_s_ff, a_s_in;

   always_comb begin
      logic [16:0] v, nv;
      logic [1:0]  k;
      v = {1'b0, in_hsv.val};
      k = 2'd0;
      nv = 17'd0;
      a_s_in = {1'b0, in_hsv.sat};
      a_v_in = v;
      if (in_index < 3'd3) begin
         a_v_in = asr_pkg::mulq16(v, asr_pkg::dark_val(in_index[1:0]));
      end else if (in_index > 3'd3) begin
         k = 2'(in_index - 3'd4);
         nv = v + asr_pkg::mulq16(17'd65535 - v, asr_pkg::light_frac(k));
         a_v_in = (nv > 17'd65535) ? 17'd65535 : nv;
         a_s_in = asr_pkg::mulq16(a_s_in, asr_pkg::light_sat(k));
      end
   end

   // stage B: chroma c = (v*s + 32767) / 65535, same reciprocal trick as to8
   logic b_vld_ff;
   logic [2:0] b_idx_ff;
   asr_pkg::hsv_type b_hsv_ff;
   logic [16:0] b_v_ff, b_c_ff, b_c_in;

   always_comb begin
      logic [33:0] n;
      logic [34:0] t;
      logic [18:0] q;
      logic [34:0] back;
      n = a_v_ff * a_s_ff + 34'd32767;
      t = {1'b0, n} + {17'd0, n[33:16]} + 35'd1;
      q = t[34:16];
      back = q * 35'd65535;
      if (back > {1'b0, n}) q = q - 19'd1;
      b_c_in = q[16:0];
   end

   // stage C: x and m, channel mix
   logic c_vld_ff;
   logic [2:0] c_idx_ff;
   asr_pkg::hsv_type c_hsv_ff;
   logic [16:0] c_r_ff, c_g_ff, c_b_ff, c_r_in, c_g_in, c_b_in;

   always_comb begin
      logic [16:0] f, x, m, cc;
      logic [2:0]  sec;
      // distance from the nearest odd sixth: hue mod 2 sixths, folded around one sixth
      f = b_hsv_ff.hue[16] ? {1'b0, b_hsv_ff.hue[15:0]}
                           : 17'(asr_pkg::SIXTH - {1'b0, b_hsv_ff.hue[15:0]});
      cc = b_c_ff;
      x = asr_pkg::mulq16(cc, 17'(asr_pkg::SIXTH - f));
      m = (b_v_ff >= cc) ? b_v_ff - cc : 17'd0;
      sec = b_hsv_ff.hue[18:16];
      c_r_in = m; c_g_in = m; c_b_in = m;
      unique case (sec)
         3'd0: begin c_r_in = cc + m; c_g_in = x + m; end
         3'd1: begin c_r_in = x + m; c_g_in = cc + m; end
         3'd2: begin c_g_in = cc + m; c_b_in = x + m; end
         3'd3: begin c_g_in = x + m; c_b_in = cc + m; end
         3'd4: begin c_r_in = x + m; c_b_in = cc + m; end
         default: begin c_r_in = cc + m; c_b_in = x + m; end
      endcase
   end

   // stage D: to 8 bits, accent shade passes the input RGB through
   logic d_vld_ff;
   asr_pkg::rsp_beat_type d_beat_ff, d_beat_in;

   always_comb begin
      d_beat_in.shade_index = c_idx_ff;
      d_beat_in.last_shade  = (c_idx_ff == 3'(asr_pkg::NUM_SHADES - 1));
      if (c_idx_ff == 3'(asr_pkg::ACCENT_SHADE)) begin
         d_beat_in.shade_red   = c_hsv_ff.red;
         d_beat_in.shade_green = c_hsv_ff.green;
         d_beat_in.shade_blue  = c_hsv_ff.blue;
      end else begin
         d_beat_in.shade_red   = asr_pkg::to8(c_r_ff);
         d_beat_in.shade_green = asr_pkg::to8(c_g_ff);
         d_beat_in.shade_blue  = asr_pkg::to8(c_b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0; b_vld_ff <= 1'b0; c_vld_ff <= 1'b0; d_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= in_valid; b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff; d_vld_ff <= c_vld_ff;
      end
      if (advance) begin
         a_idx_ff <= in_index; a_hsv_ff <= in_hsv; a_v_ff <= a_v_in; a_s_ff <= a_s_in;
         b_idx_ff <= a_idx_ff; b_hsv_ff <= a_hsv_ff; b_v_ff <= a_v_ff; b_c_ff <= b_c_in;
         c_idx_ff <= b_idx_ff; c_hsv_ff <= b_hsv_ff;
         c_r_ff <= c_r_in; c_g_ff <= c_g_in; c_b_ff <= c_b_in;
         d_beat_ff <= d_beat_in;
      end
   end

   assign out_valid = d_vld_ff;
   assign out_beat  = d_beat_ff;
endmodule

// ===== design/asr_checker.sv =====
// Port-level checks on the shade ramp top, bound to it below.
// Depends on asr_pkg.
module asr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input asr_pkg::rsp_beat_type rsp_data
);
   logic rsp_acc;
   assign rsp_acc = rsp_valid && !rsp_stall;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_shade == (rsp_data.shade_index == 3'd6))
      else $error("last flag mismatch");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shade_index != 3'd7)
      else $error("bad shade index");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && !rsp_data.last_shade ##1 rsp_valid |->
      rsp_data.shade_index == $past(rsp_data.shade_index) + 3'd1 ||
      rsp_data.shade_index == $past(rsp_data.shade_index))
      else $error("shade order broken");
endmodule

bind accent_shade_ramp_top asr_checker u_asr_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data);

// ===== tb/sv/accent_shade_ramp_top_tb.sv =====
// Testbench for accent_shade_ramp_top: accent colors in, seven shades per accent checked
// against an in-bench HSV shade predictor. Depends on asr_pkg and the top level RTL.
`timescale 1ns / 100ps

module accent_shade_ramp_top_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   asr_pkg::req_beat_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   asr_pkg::rsp_beat_type rsp_data;

   asr_pkg::rsp_beat_type shade_queue[$];
   int  error_count;
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  hold_rsp;
   int  idle_cycles;

   accent_shade_ramp_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b + 32768) >> 16;
   endfunction

   function automatic logic [7:0] chan8(longint unsigned c);
      longint unsigned q;
      q = (c * 255 + 32767) / 65535;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic longint signed hue_frac(longint signed diff, longint unsigned delta);
      longint unsigned mag;
      longint unsigned q;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * 65536 + delta / 2) / delta;
      return (diff < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic asr_pkg::rsp_beat_type hsv_shade(longint unsigned h,
                                                       longint unsigned s,
                                                       longint unsigned v, int idx);
      asr_pkg::rsp_beat_type sh;
      longint unsigned c, t, f, x, m, sector, r, g, b;
      c = (v * s + 32767) / 65535;
      t = h % (2 * 65536);
      f = (t >= 65536) ? t - 65536 : 65536 - t;
      x = qmul(c, 65536 - f);
      m = (v >= c) ? v - c : 0;
      sector = h >> 16;
      r = 0; g = 0; b = 0;
      case (sector)
         0: begin r = c; g = x; end
         1: begin r = x; g = c; end
         2: begin g = c; b = x; end
         3: begin g = x; b = c; end
         4: begin r = x; b = c; end
         default: begin r = c; b = x; end
      endcase
      sh.shade_index = idx[2:0];
      sh.shade_red   = chan8(r + m);
      sh.shade_green = chan8(g + m);
      sh.shade_blue  = chan8(b + m);
      sh.last_shade  = (idx == asr_pkg::NUM_SHADES - 1);
      return sh;
   endfunction

   task automatic predict_shades(asr_pkg::req_beat_type acc);
      longint unsigned dark_k[3]  = '{24143, 34059, 47428};
      longint unsigned frac_k[3]  = '{47042, 58537, 65536};
      longint unsigned satk_k[3]  = '{47487, 30691, 21496};
      longint unsigned r, g, b, mx, mn, delta, h, s, v, nv;
      longint signed hs;
      asr_pkg::rsp_beat_type sh;
      r = acc.accent_red; g = acc.accent_green; b = acc.accent_blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h = 0;
      if (delta > 0) begin
         // ties: red wins over green, green over blue
         if (mx == r)      hs = hue_frac(longint'(g) - longint'(b), delta);
         else if (mx == g) hs = hue_frac(longint'(b) - longint'(r), delta) + 2 * 65536;
         else              hs = hue_frac(longint'(r) - longint'(g), delta) + 4 * 65536;
         if (hs < 0) hs += 6 * 65536;
         h = hs;
         if (h >= 6 * 65536) h -= 6 * 65536;
      end
      v = mx * 257;
      s = (mx > 0) ? (delta * 65535 + mx / 2) / mx : 0;
      for (int k = 0; k < asr_pkg::NUM_SHADES; k++) begin
         if (k < 3) begin
            sh = hsv_shade(h, s, qmul(v, dark_k[k]), k);
         end else if (k == asr_pkg::ACCENT_SHADE) begin
            sh.shade_index = k[2:0];
            sh.shade_red = acc.accent_red;
            sh.shade_green = acc.accent_green;
            sh.shade_blue = acc.accent_blue;
            sh.last_shade = 1'b0;
         end else begin
            nv = v + qmul(65535 - v, frac_k[k-4]);
            if (nv > 65535) nv = 65535;
            sh = hsv_shade(h, qmul(s, satk_k[k-4]), nv, k);
         end
         shade_queue.push_back(sh);
      end
   endtask

   // valid stays up after a beat so the next one can follow without a gap
   task automatic send_accent(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      asr_pkg::req_beat_type acc;
      acc.accent_red = r; acc.accent_green = g; acc.accent_blue = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= acc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_shades(acc);
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = int'($urandom_range(9));
         if (pick == 0) begin
            logic [7:0] gv;
            gv = 8'($urandom);
            send_accent(gv, gv, gv);
         end else if (pick == 1) begin
            logic [7:0] tv;
            tv = 8'($urandom);
            send_accent(tv, tv, 8'($urandom));
         end else begin
            send_accent(8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (shade_queue.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0; rsp_stall_pct = 0;
      send_accent(8'd0, 8'd0, 8'd0);
      send_accent(8'd255, 8'd255, 8'd255);
      send_accent(8'd128, 8'd128, 8'd128);
      send_accent(8'd255, 8'd0, 8'd0);
      send_accent(8'd0, 8'd255, 8'd0);
      send_accent(8'd0, 8'd0, 8'd255);
      send_accent(8'd255, 8'd0, 8'd1);
      send_accent(8'd255, 8'd255, 8'd0);
      send_accent(8'd0, 8'd255, 8'd255);
      send_accent(8'd255, 8'd0, 8'd255);
      send_accent(8'd200, 8'd200, 8'd10);
      send_accent(8'd10, 8'd200, 8'd200);
      send_accent(8'd1, 8'd0, 8'd0);
      send_accent(8'd0, 8'd1, 8'd1);
      send_accent(8'd170, 8'd85, 8'd85);
      send_accent(8'd85, 8'd170, 8'd170);
      send_accent(8'd254, 8'd1, 8'd127);
      send_accent(8'd1, 8'd254, 8'd128);
      wait_drained();
   endtask

   task automatic test_idle_phases();
      send_idle_pct = 0;  rsp_stall_pct = 0;  send_random(90);
      send_idle_pct = 71; rsp_stall_pct = 0;  send_random(70);
      send_idle_pct = 0;  rsp_stall_pct = 71; send_random(70);
      send_idle_pct = 31; rsp_stall_pct = 31; send_random(70);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0; rsp_stall_pct = 0;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         send_random(30);
      join
      // pause until everything is out, then resume
      wait_drained();
      send_random(20);
      wait_drained();
   endtask

   // receiver side
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      asr_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shade_queue.size() == 0) begin
            $display("%0t: unexpected shade %h", $time, rsp_data);
            error_count++;
         end else begin
            want = shade_queue.pop_front();
            if (rsp_data.shade_index !== want.shade_index)
               begin $display("%0t: shade_index exp %0d got %0d", $time,
                        want.shade_index, rsp_data.shade_index); error_count++; end
            if (rsp_data.shade_red !== want.shade_red)
               begin $display("%0t: shade_red exp %0d got %0d", $time,
                        want.shade_red, rsp_data.shade_red); error_count++; end
            if (rsp_data.shade_green !== want.shade_green)
               begin $display("%0t: shade_green exp %0d got %0d", $time,
                        want.shade_green, rsp_data.shade_green); error_count++; end
            if (rsp_data.shade_blue !== want.shade_blue)
               begin $display("%0t: shade_blue exp %0d got %0d", $time,
                        want.shade_blue, rsp_data.shade_blue); error_count++; end
            if (rsp_data.last_shade !== want.last_shade)
               begin $display("%0t: last_shade exp %0d got %0d", $time,
                        want.last_shade, rsp_data.last_shade); error_count++; end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 0; rsp_stall_pct = 0; hold_rsp = 1'b0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_idle_phases();
      test_backpressure();
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && shade_queue.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
